// ----- design/vmx_pkg.sv -----
// Package for the voice mixer: payload structs, request codes and constants.
// Used by every module of the mixer; depends on nothing.
`default_nettype none
package vmx_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_VOICE = 2'd1,
    REQ_MUSIC = 2'd2,
    REQ_FRAME = 2'd3
  } req_type_t;

  localparam logic [1:0] MOP_NEW      = 2'd0;
  localparam logic [1:0] MOP_STOP     = 2'd1;
  localparam logic [1:0] MOP_REASSERT = 2'd2;

  localparam logic [1:0] CFG_MASTER = 2'd0;
  localparam logic [1:0] CFG_MUSIC  = 2'd1;
  localparam logic [1:0] CFG_FADE   = 2'd2;

  localparam logic [24:0] GAIN_UNITY = 25'd16777216;
  localparam logic [24:0] FADE_FLOOR = 25'd1677;
  localparam logic [15:0] VOL_UNITY  = 16'd32768;
  localparam int          CFG_W      = 25;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [15:0]        voice_base;
    logic [16:0]        voice_length;
    logic [1:0]         music_op;
    logic signed [15:0] music_sample_a;
    logic signed [15:0] music_sample_b;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] mix_sample;
    logic               clipped;
    logic [4:0]         active_voices;
  } out_word_t;

endpackage
`default_nettype wire

// ----- design/vmx_queue.sv -----
// Two-entry word queue between the front and the back of the voice mixer.
// Depends on vmx_pkg for the input word type.
`default_nettype none
module vmx_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  vmx_pkg::in_word_t      push_word,
  output logic                   full,
  input  wire logic              pop,
  output vmx_pkg::in_word_t      pop_word,
  output logic                   not_empty
);
  vmx_pkg::in_word_t slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue underflow");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
endmodule
`default_nettype wire

// ----- design/vmx_back.sv -----
// Back end of the voice mixer: sample memory, voice list, music slots and mix.
// Depends on vmx_pkg for the word types, codes and constants.
`default_nettype none
module vmx_back #(
  parameter int VOICE_SLOTS  = 17,
  parameter int SAMPLE_WORDS = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [vmx_pkg::CFG_W-1:0] cfg_data,
  input  vmx_pkg::in_word_t      word,
  input  wire logic              word_valid,
  output logic                   word_take,
  output vmx_pkg::out_word_t     out_word,
  output logic                   out_valid,
  input  wire logic              out_stall
);
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int VW = $clog2(VOICE_SLOTS);
  localparam int CW = $clog2(VOICE_SLOTS + 1);
  localparam int SW = 17 + CW;

  typedef enum logic [2:0] {
    S_IDLE, S_VREAD, S_VACC, S_MUSIC, S_MSCALE, S_ROUND
  } state_t;

  state_t state;
  logic signed [15:0] mem [SAMPLE_WORDS];
  logic [15:0] v_start [VOICE_SLOTS];
  logic [16:0] v_len   [VOICE_SLOTS];
  logic [16:0] v_pos   [VOICE_SLOTS];
  logic [CW-1:0] v_count;
  logic [CW-1:0] rd_i;
  logic [CW-1:0] wr_i;
  logic        rd_live;
  logic signed [15:0] rd_data;
  logic signed [SW-1:0] vsum;
  logic [24:0] gain [2];
  logic        tgt_up [2];
  logic        svalid [2];
  logic [1:0]  active;
  logic [15:0] master;
  logic [15:0] music;
  logic [24:0] fade;
  logic [15:0] mm;
  logic        slot;
  logic [40:0] gm;
  logic signed [15:0] msamp;
  logic signed [63:0] acc;
  vmx_pkg::in_word_t cur;

  logic [15:0] vol_sat;
  logic [24:0] g_new;
  logic        slot_live;
  logic [25:0] g_up;
  logic [16:0] pos_inc;
  logic [16:0] addr_sum;
  logic signed [63:0] rnd;
  logic signed [24:0] q;
  logic [VW-1:0] ri;
  logic        out_free;

  function automatic logic cur_is_write(vmx_pkg::in_word_t w);
    return w.req_type == vmx_pkg::REQ_WRITE;
  endfunction

  assign ri      = rd_i[VW-1:0];
  assign vol_sat = (cfg_data[15:0] > vmx_pkg::VOL_UNITY) ? vmx_pkg::VOL_UNITY : cfg_data[15:0];
  assign g_up    = {1'b0, gain[slot]} + {1'b0, fade};
  assign slot_live = svalid[slot] && (tgt_up[slot] || gain[slot] > vmx_pkg::FADE_FLOOR);
  always_comb begin
    if (tgt_up[slot]) begin
      g_new = (g_up > {1'b0, vmx_pkg::GAIN_UNITY}) ? vmx_pkg::GAIN_UNITY : g_up[24:0];
    end else begin
      g_new = (gain[slot] > fade) ? gain[slot] - fade : 25'd0;
    end
  end
  assign pos_inc  = v_pos[ri] + 17'd1;
  assign addr_sum = {1'b0, v_start[ri]} + v_pos[ri];
  assign rnd      = acc + (64'sd1 <<< 38);
  assign q        = 25'(rnd >>> 39);
  assign word_take = (state == S_IDLE) && word_valid;
  // The output register can take a new word when it is empty or being read.
  assign out_free  = !out_valid || !out_stall;

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (word_take && cur_is_write(word)) begin
      mem[AW'(word.sample_address)] <= word.sample_value;
    end
    rd_data <= mem[AW'(addr_sum)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      v_count   <= '0;
      gain[0] <= '0; gain[1] <= '0;
      tgt_up[0] <= 1'b0; tgt_up[1] <= 1'b0;
      svalid[0] <= 1'b0; svalid[1] <= 1'b0;
      active    <= 2'd0;
      master    <= vmx_pkg::VOL_UNITY;
      music     <= 16'd18022;
      fade      <= 25'd233;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          vmx_pkg::CFG_MASTER: master <= vol_sat;
          vmx_pkg::CFG_MUSIC:  music  <= vol_sat;
          vmx_pkg::CFG_FADE:   fade   <= cfg_data;
          default: ;
        endcase
      end
      out_valid <= ((state == S_ROUND) && out_free) || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (word_take) begin
            cur <= word;
            case (word.req_type)
              vmx_pkg::REQ_VOICE: begin
                if (v_count >= CW'(VOICE_SLOTS)) begin
                  for (int i = 1; i < VOICE_SLOTS; i++) begin
                    v_start[i-1] <= v_start[i];
                    v_len[i-1]   <= v_len[i];
                    v_pos[i-1]   <= v_pos[i];
                  end
                  v_start[VOICE_SLOTS-1] <= word.voice_base;
                  v_len[VOICE_SLOTS-1]   <= word.voice_length;
                  v_pos[VOICE_SLOTS-1]   <= '0;
                end else begin
                  v_start[v_count[VW-1:0]] <= word.voice_base;
                  v_len[v_count[VW-1:0]]   <= word.voice_length;
                  v_pos[v_count[VW-1:0]]   <= '0;
                  v_count <= v_count + 1'b1;
                end
              end
              vmx_pkg::REQ_MUSIC: begin
                case (word.music_op)
                  vmx_pkg::MOP_NEW: begin
                    if (active == 2'd1) begin
                      tgt_up[0] <= 1'b0;
                      svalid[1] <= 1'b1; gain[1] <= '0; tgt_up[1] <= 1'b1;
                      active <= 2'd2;
                    end else begin
                      if (active == 2'd2) tgt_up[1] <= 1'b0;
                      svalid[0] <= 1'b1; gain[0] <= '0; tgt_up[0] <= 1'b1;
                      active <= 2'd1;
                    end
                  end
                  vmx_pkg::MOP_STOP: begin
                    if (active == 2'd1) tgt_up[0] <= 1'b0;
                    if (active == 2'd2) tgt_up[1] <= 1'b0;
                    active <= 2'd0;
                  end
                  vmx_pkg::MOP_REASSERT: begin
                    if (active == 2'd1 && svalid[0]) tgt_up[0] <= 1'b1;
                    if (active == 2'd2 && svalid[1]) tgt_up[1] <= 1'b1;
                  end
                  default: ;
                endcase
              end
              vmx_pkg::REQ_FRAME: begin
                rd_i  <= '0;
                wr_i  <= '0;
                vsum  <= '0;
                mm    <= 16'(({16'd0, master} * {16'd0, music} + 32'd16384) >> 15);
                state <= S_VREAD;
              end
              default: ;
            endcase
          end
        end
        S_VREAD: begin
          // Memory read is issued at addr_sum of voice rd_i.
          if (rd_i >= v_count) begin
            v_count <= wr_i;
            acc     <= 64'(vsum * $signed({1'b0, master})) <<< 24;
            slot    <= 1'b0;
            state   <= S_MUSIC;
          end else begin
            rd_live <= v_pos[ri] < v_len[ri];
            state   <= S_VACC;
          end
        end
        S_VACC: begin
          if (rd_live) begin
            vsum <= vsum + SW'(rd_data);
          end
          if (rd_live && pos_inc < v_len[ri]) begin
            v_start[wr_i[VW-1:0]] <= v_start[ri];
            v_len[wr_i[VW-1:0]]   <= v_len[ri];
            v_pos[wr_i[VW-1:0]]   <= pos_inc;
            wr_i <= wr_i + 1'b1;
          end
          rd_i  <= rd_i + 1'b1;
          state <= S_VREAD;
        end
        S_MUSIC: begin
          if (slot_live) begin
            gain[slot] <= g_new;
            gm    <= {16'd0, g_new} * {25'd0, mm};
            msamp <= slot ? cur.music_sample_b : cur.music_sample_a;
            state <= S_MSCALE;
          end else if (slot) begin
            state <= S_ROUND;
          end else begin
            slot <= 1'b1;
          end
        end
        S_MSCALE: begin
          acc <= acc + 64'(msamp * $signed({1'b0, gm}));
          if (slot) begin
            state <= S_ROUND;
          end else begin
            slot  <= 1'b1;
            state <= S_MUSIC;
          end
        end
        S_ROUND: begin
          // The finished word waits here while the previous one is stalled.
          if (out_free) begin
            if (q > 25'sd32767) begin
              out_word.mix_sample <= 16'sd32767; out_word.clipped <= 1'b1;
            end else if (q < -25'sd32768) begin
              out_word.mix_sample <= -16'sd32768; out_word.clipped <= 1'b1;
            end else begin
              out_word.mix_sample <= q[15:0]; out_word.clipped <= 1'b0;
            end
            out_word.active_voices <= 5'(v_count);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) v_count <= CW'(VOICE_SLOTS))
    else $error("voice count out of range");
  a_active_code: assert property (@(posedge clk) disable iff (rst) active != 2'd3)
    else $error("bad active slot");
  a_active_valid: assert property (@(posedge clk) disable iff (rst)
    (active == 2'd1 |-> svalid[0]) and (active == 2'd2 |-> svalid[1]))
    else $error("active slot not valid");
endmodule
`default_nettype wire

// ----- design/voice_mixer_with_music_crossfade_core.sv -----
// Top level of the voice mixer: input front, word queue and mixing back end.
// Depends on vmx_pkg, vmx_queue and vmx_back.
//
// Input words enter on in_valid/in_stall and sit in a two-entry queue, so the
// front side accepts while the back end works. The back end handles one word
// at a time: a sample write, voice start or music command is applied in the
// idle state; a frame tick walks the queued voices with one sample memory read
// and one accumulate each, then closes the voice walk, scales the music slots
// and rounds. The sample memory read port sets the voice pace.
// Frame ticks give one result word on out_valid/out_stall, held in an output
// register; while the receiver stalls, the back end carries on until its next
// result is ready and waits with it, and the queue then fills and raises in_stall.
// Synchronous reset empties the queue, clears the voice list and both music
// slots and loads the register defaults. The sample memory is not cleared.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once. The user
// must make them only while the mixer is idle; the block does not enforce this.
`default_nettype none
module voice_mixer_with_music_crossfade_core #(
  parameter int VOICE_SLOTS  = 17,
  parameter int SAMPLE_WORDS = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [24:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  vmx_pkg::in_word_t      in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vmx_pkg::out_word_t     out_word
);
  vmx_pkg::in_word_t q_word;
  logic q_full;
  logic q_ne;
  logic take;

  // The front accepts whenever the queue has room.
  assign in_stall = q_full;

  vmx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_word (in_word),
    .full      (q_full),
    .pop       (take),
    .pop_word  (q_word),
    .not_empty (q_ne)
  );

  vmx_back #(
    .VOICE_SLOTS  (VOICE_SLOTS),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .word       (q_word),
    .word_valid (q_ne),
    .word_take  (take),
    .out_word   (out_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for voice_mixer_with_music_crossfade_core.
// Depends on vmx_pkg and the core; the expected mix words come from a predictor in this file.
`default_nettype none
module testbench;

  // Register index with no register behind it; a write there must be ignored.
  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int VOICES = 17;
  // Cycles allowed after the last result for non-frame words still in the core.
  localparam int DRAIN_CYCLES = 80;
  // Cycles with no word moved on any port before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 500;

  // Short names for the directed table.
  localparam vmx_pkg::req_type_t RQ_WR = vmx_pkg::REQ_WRITE;
  localparam vmx_pkg::req_type_t RQ_VO = vmx_pkg::REQ_VOICE;
  localparam vmx_pkg::req_type_t RQ_MU = vmx_pkg::REQ_MUSIC;
  localparam vmx_pkg::req_type_t RQ_FR = vmx_pkg::REQ_FRAME;
  localparam logic [1:0] OP_NEW      = vmx_pkg::MOP_NEW;
  localparam logic [1:0] OP_STOP     = vmx_pkg::MOP_STOP;
  localparam logic [1:0] OP_REASSERT = vmx_pkg::MOP_REASSERT;
  // Music op with no meaning; the mixer ignores it.
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [24:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  vmx_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vmx_pkg::out_word_t out_word;

  voice_mixer_with_music_crossfade_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // ---------------------------------------------------------------------
  // Mixer predictor. It runs as words are generated; since the core keeps
  // word order, the expected mix words line up with the core's results.
  // ---------------------------------------------------------------------
  logic signed [15:0] pcm_mem [65536];
  bit                 pcm_written [65536];
  logic [15:0]        vq_base [VOICES];
  logic [16:0]        vq_len [VOICES];
  logic [16:0]        vq_pos [VOICES];
  int                 vq_cnt;
  int unsigned        fade_gain [2];
  bit                 fade_up [2];
  bit                 slot_live [2];
  int unsigned        playing_slot;
  int unsigned        master_gain, music_gain, fade_rate;

  vmx_pkg::in_word_t  word_fifo [$];
  vmx_pkg::out_word_t mix_expected [$];

  int words_made, ticks_made, mixes_seen, errors;

  function automatic void predictor_reset();
    vq_cnt = 0;
    fade_gain = '{0, 0};
    fade_up = '{0, 0};
    slot_live = '{0, 0};
    playing_slot = 0;
    master_gain = 32768;
    music_gain = 18022;
    fade_rate = 233;
  endfunction

  function automatic void predict_register(logic [1:0] idx, logic [24:0] data);
    case (idx)
      vmx_pkg::CFG_MASTER:
        master_gain = (data[15:0] > vmx_pkg::VOL_UNITY) ? 32768 : {16'd0, data[15:0]};
      vmx_pkg::CFG_MUSIC:
        music_gain = (data[15:0] > vmx_pkg::VOL_UNITY) ? 32768 : {16'd0, data[15:0]};
      vmx_pkg::CFG_FADE:   fade_rate = {7'd0, data};
      default: ;
    endcase
  endfunction

  // Applies one word to the predicted state. Returns 1 with the mix word
  // for a frame tick, 0 for every other word.
  function automatic bit predict_word(vmx_pkg::in_word_t w, output vmx_pkg::out_word_t mix);
    longint vsum, acc, q;
    int unsigned mm, g;
    int kept;
    logic [15:0] a;
    bit clip;
    mix = '0;
    case (w.req_type)
      vmx_pkg::REQ_WRITE: begin
        pcm_mem[w.sample_address] = w.sample_value;
        pcm_written[w.sample_address] = 1'b1;
        return 1'b0;
      end
      vmx_pkg::REQ_VOICE: begin
        // A full list drops its oldest voice and keeps the order of the rest.
        if (vq_cnt >= VOICES) begin
          for (int i = 1; i < VOICES; i++) begin
            vq_base[i-1] = vq_base[i];
            vq_len[i-1] = vq_len[i];
            vq_pos[i-1] = vq_pos[i];
          end
          vq_cnt = VOICES - 1;
        end
        vq_base[vq_cnt] = w.voice_base;
        vq_len[vq_cnt] = w.voice_length;
        vq_pos[vq_cnt] = '0;
        vq_cnt++;
        return 1'b0;
      end
      vmx_pkg::REQ_MUSIC: begin
        if (w.music_op == vmx_pkg::MOP_NEW) begin
          if (playing_slot != 0) fade_up[playing_slot-1] = 1'b0;
          g = (playing_slot == 1) ? 1 : 0;
          slot_live[g] = 1'b1;
          fade_gain[g] = 0;
          fade_up[g] = 1'b1;
          playing_slot = g + 1;
        end else if (w.music_op == vmx_pkg::MOP_STOP) begin
          if (playing_slot != 0) fade_up[playing_slot-1] = 1'b0;
          playing_slot = 0;
        end else if (w.music_op == vmx_pkg::MOP_REASSERT) begin
          if (playing_slot != 0 && slot_live[playing_slot-1])
            fade_up[playing_slot-1] = 1'b1;
        end
        return 1'b0;
      end
      default: begin
        vsum = 0;
        kept = 0;
        for (int i = 0; i < vq_cnt; i++) begin
          if (vq_pos[i] < vq_len[i]) begin
            a = vq_base[i] + vq_pos[i][15:0];
            vsum += pcm_mem[a];
            vq_pos[i]++;
          end
          if (vq_pos[i] < vq_len[i]) begin
            vq_base[kept] = vq_base[i];
            vq_len[kept] = vq_len[i];
            vq_pos[kept] = vq_pos[i];
            kept++;
          end
        end
        vq_cnt = kept;
        acc = vsum * longint'(master_gain) * 64'sd16777216;
        mm = (master_gain * music_gain + 16384) >> 15;
        for (int s = 0; s < 2; s++) begin
          // A slot that has faded out to or below the floor is silent and frozen.
          if (!slot_live[s] || (fade_gain[s] <= vmx_pkg::FADE_FLOOR && !fade_up[s])) continue;
          g = fade_gain[s];
          if (fade_up[s])
            g = (g + fade_rate > vmx_pkg::GAIN_UNITY) ? vmx_pkg::GAIN_UNITY : g + fade_rate;
          else g = (g > fade_rate) ? g - fade_rate : 0;
          fade_gain[s] = g;
          acc += longint'(s == 0 ? w.music_sample_a : w.music_sample_b)
                 * (longint'(g) * longint'(mm));
        end
        q = (acc + (64'sd1 << 38)) >>> 39;
        clip = 1'b0;
        if (q > 32767) begin
          q = 32767;
          clip = 1'b1;
        end
        if (q < -32768) begin
          q = -32768;
          clip = 1'b1;
        end
        mix.mix_sample = q[15:0];
        mix.clipped = clip;
        mix.active_voices = vq_cnt[4:0];
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Word generation.
  // ---------------------------------------------------------------------
  function automatic vmx_pkg::in_word_t noise_word();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return vmx_pkg::in_word_t'(raw[$bits(vmx_pkg::in_word_t)-1:0]);
  endfunction

  function automatic void queue_word(vmx_pkg::in_word_t w, bit typed = 0,
                                     vmx_pkg::out_word_t want = '0);
    vmx_pkg::out_word_t mix;
    if (predict_word(w, mix)) begin
      mix_expected = {mix_expected, typed ? want : mix};
      ticks_made++;
    end
    word_fifo = {word_fifo, w};
    words_made++;
  endfunction

  // Sample memory is not cleared by reset, so every word that the next tick
  // will read gets written first.
  function automatic void queue_frame(vmx_pkg::in_word_t w, bit typed = 0,
                                      vmx_pkg::out_word_t want = '0);
    vmx_pkg::in_word_t fill;
    logic [15:0] a;
    for (int i = 0; i < vq_cnt; i++) begin
      if (vq_pos[i] < vq_len[i]) begin
        a = vq_base[i] + vq_pos[i][15:0];
        if (!pcm_written[a]) begin
          fill = noise_word();
          fill.req_type = vmx_pkg::REQ_WRITE;
          fill.sample_address = a;
          queue_word(fill);
        end
      end
    end
    w.req_type = vmx_pkg::REQ_FRAME;
    queue_word(w, typed, want);
  endfunction

  // Random words: mostly short voices over a small buffer region so that
  // the list fills, evicts and drains, with rare long or wrapping voices.
  function automatic void queue_random(int count);
    vmx_pkg::in_word_t w;
    int pick;
    for (int n = 0; n < count; n++) begin
      w = noise_word();
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        queue_frame(w);
      end else if (pick < 60) begin
        w.req_type = vmx_pkg::REQ_VOICE;
        if ($urandom_range(0, 19) != 0) begin
          w.voice_base = 16'($urandom_range(0, 63));
          w.voice_length = 17'($urandom_range(0, 24));
        end
        queue_word(w);
      end else if (pick < 70) begin
        w.req_type = vmx_pkg::REQ_MUSIC;
        if ($urandom_range(0, 9) == 0) w.music_op = 2'($urandom_range(0, 3));
        else if ($urandom_range(0, 2) == 0) w.music_op = vmx_pkg::MOP_NEW;
        else w.music_op = 2'($urandom_range(1, 2));
        queue_word(w);
      end else begin
        w.req_type = vmx_pkg::REQ_WRITE;
        if ($urandom_range(0, 3) != 0) w.sample_address = 16'($urandom_range(0, 90));
        queue_word(w);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input side: bursts of random length with random gaps. A word that was
  // not taken stays on the port unchanged.
  // ---------------------------------------------------------------------
  bit in_took;
  int burst_left = 0;
  int gap_left = 0;
  int moved_cycles = 0;

  always @(posedge clk) begin
    in_took = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      void'(word_fifo.pop_front());
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_took) begin
        // Still waiting on the stalled word.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (word_fifo.size() > 0) begin
        in_valid <= 1'b1;
        in_word <= word_fifo[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output side: the stall rate is redrawn whenever stall_phase wraps, including runs
  // with no stall at all. A long hold-off fills the core and its queue.
  // ---------------------------------------------------------------------
  bit hold_request = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int stall_phase = 0;
  int holds_done = 0;

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_phase = (stall_phase + 1) % 64;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Checks each mix word taken from the core against the oldest expected one.
  always @(posedge clk) begin
    vmx_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      mixes_seen++;
      if (mix_expected.size() == 0) begin
        $display("%0t: unexpected mix word %p", $time, out_word);
        errors++;
      end else begin
        want = mix_expected.pop_front();
        if (out_word.mix_sample !== want.mix_sample) begin
          $display("%0t: mix_sample expected %0d actual %0d", $time,
                   want.mix_sample, out_word.mix_sample);
          errors++;
        end
        if (out_word.clipped !== want.clipped) begin
          $display("%0t: clipped expected %0b actual %0b", $time,
                   want.clipped, out_word.clipped);
          errors++;
        end
        if (out_word.active_voices !== want.active_voices) begin
          $display("%0t: active_voices expected %0d actual %0d", $time,
                   want.active_voices, out_word.active_voices);
          errors++;
        end
      end
    end
  end

  // Hang detection: any word moved on either port, a register write or reset resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst)
      moved_cycles = 0;
    else
      moved_cycles++;
    if (moved_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_register(logic [1:0] idx, logic [24:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    predict_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every word is taken and every mix word has come back, then
  // gives trailing non-frame words time to leave the core.
  task automatic drain();
    while (word_fifo.size() != 0 || in_valid || mix_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  typedef struct {
    vmx_pkg::req_type_t kind;
    logic [15:0]        addr;
    logic [15:0]        value;
    logic [16:0]        len;
    logic [1:0]         op;
    logic [15:0]        mus_a;
    logic [15:0]        mus_b;
    bit                 typed;
    vmx_pkg::out_word_t want;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    // Silence after reset, even with full-scale music on idle slots.
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h7FFF, 16'h8000, 1, '{16'sd0, 1'b0, 5'd0}},
    '{RQ_WR, 16'h0000, 16'h7FFF, 17'd0, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_WR, 16'hFFFF, 16'h8000, 17'd0, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_WR, 16'h0001, 16'h7FFF, 17'd0, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    // A voice at the top of memory wraps to address zero; a zero-length voice
    // plays nothing and is gone after the next tick.
    '{RQ_VO, 16'hFFFF, 16'h0000, 17'd2, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_VO, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h1234, 16'h4321, 1,
      '{-16'sd32768, 1'b0, 5'd1}},
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h1234, 16'h4321, 1,
      '{16'sd32767, 1'b0, 5'd0}},
    // Three full-scale voices clip high; the one-sample voice finishes.
    '{RQ_VO, 16'h0000, 16'h0000, 17'd3, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_VO, 16'h0001, 16'h0000, 17'd3, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_VO, 16'h0000, 16'h0000, 17'd1, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h0000, 16'h0000, 1,
      '{16'sd32767, 1'b1, 5'd2}},
    // Music commands: new track, reassert, the unused op, a crossfade, stops, a late reassert.
    '{RQ_MU, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h7FFF, 16'h8000, 0, '0},
    '{RQ_MU, 16'h0000, 16'h0000, 17'd0, OP_REASSERT, 16'h0000, 16'h0000, 0, '0},
    '{RQ_MU, 16'h0000, 16'h0000, 17'd0, OP_UNUSED, 16'h0000, 16'h0000, 0, '0},
    '{RQ_MU, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h7FFF, 16'h7FFF, 0, '0},
    '{RQ_MU, 16'h0000, 16'h0000, 17'd0, OP_STOP, 16'h0000, 16'h0000, 0, '0},
    '{RQ_MU, 16'h0000, 16'h0000, 17'd0, OP_STOP, 16'h0000, 16'h0000, 0, '0},
    '{RQ_MU, 16'h0000, 16'h0000, 17'd0, OP_REASSERT, 16'h0000, 16'h0000, 0, '0},
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h8000, 16'h8000, 0, '0},
    // Two full-scale negative voices clip low.
    '{RQ_VO, 16'hFFFF, 16'h0000, 17'd1, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_VO, 16'hFFFF, 16'h0000, 17'd1, OP_NEW, 16'h0000, 16'h0000, 0, '0},
    '{RQ_FR, 16'h0000, 16'h0000, 17'd0, OP_NEW, 16'h0000, 16'h0000, 1,
      '{-16'sd32768, 1'b1, 5'd0}}
  };

  // Register settings per random phase: unity and fastest fade, zero volumes with the slowest
  // fade, saturating writes with a frozen fade, a step above unity, then default volumes with a faster fade.
  logic [24:0] phase_regs [5][3] = '{
    '{25'd32768, 25'd32768, 25'd16777216},
    '{25'd0, 25'd0, 25'd1},
    '{25'd65535, 25'd40000, 25'd0},
    '{25'd12345, 25'd20000, 25'h1FFFFFF},
    '{25'd32768, 25'd18022, 25'd3000}
  };

  initial begin
    vmx_pkg::in_word_t w;
    dir_row_t r;
    predictor_reset();
    words_made = 0;
    ticks_made = 0;
    mixes_seen = 0;
    errors = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      w = noise_word();
      w.req_type = r.kind;
      w.sample_address = r.addr;
      w.sample_value = r.value;
      w.voice_base = r.addr;
      w.voice_length = r.len;
      w.music_op = r.op;
      w.music_sample_a = r.mus_a;
      w.music_sample_b = r.mus_b;
      if (r.kind == vmx_pkg::REQ_FRAME) queue_frame(w, r.typed, r.want);
      else queue_word(w, r.typed, r.want);
    end
    drain();

    for (int p = 0; p < 5; p++) begin
      write_register(vmx_pkg::CFG_MASTER, phase_regs[p][0]);
      write_register(vmx_pkg::CFG_MUSIC, phase_regs[p][1]);
      write_register(vmx_pkg::CFG_FADE, phase_regs[p][2]);
      if (p == 0) write_register(CFG_NONE, 25'h1FFFFFF);
      // In the second phase the receiver holds off while words keep coming.
      if (p == 1) hold_request = 1;
      queue_random(185);
      drain();
    end

    $display("Ran %0d words (%0d frame ticks, %0d mix words checked) over 6 register settings,",
             words_made, ticks_made, mixes_seen);
    $display("with %0d long output hold-off(s) and %0d mismatches.", holds_done, errors);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// ----- voice_mixer_with_music_crossfade_core.f -----
design/vmx_pkg.sv
design/vmx_queue.sv
design/vmx_back.sv
design/voice_mixer_with_music_crossfade_core.sv
tb/sv/testbench.sv
